// File: src/rhtb_pkg.sv
package rhtb_pkg;

	// fixed field widths
	localparam int HEIGHT_W   = 23;
	localparam int FRAC_IN_W  = 16;
	localparam int INDEX_W    = 16;
	localparam int SIZE_CFG_W = 9;
	localparam int BYTE_W     = 8;

	// request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// tile size after reset
	localparam logic [SIZE_CFG_W-1:0] TILE_SIZE_RESET = SIZE_CFG_W'(256);

	// query sequencer states
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MUL  = 9'b000000010,
		ST_ROW  = 9'b000000100,
		ST_RD0  = 9'b000001000,
		ST_RD1  = 9'b000010000,
		ST_RD2  = 9'b000100000,
		ST_RD3  = 9'b001000000,
		ST_WT   = 9'b010000000,
		ST_FIN  = 9'b100000000
	} seq_state_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

endpackage

// File: src/rhtb_ram.sv
module rhtb_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: src/rhtb_seq.sv
module rhtb_seq #(
	parameter int MAX_TILE_SIZE = 256,
	parameter int FRACTION_BITS = 16,
	localparam int AW = $clog2(MAX_TILE_SIZE * MAX_TILE_SIZE)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rhtb_pkg::FRAC_IN_W-1:0]      frac_x,
	input  logic [rhtb_pkg::FRAC_IN_W-1:0]      frac_y,
	input  logic [rhtb_pkg::SIZE_CFG_W-1:0]     tile_size,
	input  logic                                out_free,
	input  logic [rhtb_pkg::HEIGHT_W-1:0]       rd_data,
	output logic [AW-1:0]                       rd_addr,
	output rhtb_pkg::seq_stat_t                 stat,
	output logic [rhtb_pkg::HEIGHT_W-1:0]       result
);

	import rhtb_pkg::*;

	localparam int FB = FRACTION_BITS;
	localparam int SW = $clog2(MAX_TILE_SIZE + 1);
	localparam int LW = $clog2(MAX_TILE_SIZE);
	localparam int PW = FB + LW;
	localparam int RW = LW + SW;
	localparam int HW = HEIGHT_W;

	// a + floor((b - a) * w / 2^FB), equal to the truncated two-product blend
	function automatic logic [HW-1:0] blend(input logic [HW-1:0] a, input logic [HW-1:0] b,
		input logic [FB-1:0] w);
		logic signed [HW:0]      diff;
		logic signed [HW+FB+1:0] prod;
		logic signed [HW+FB+1:0] shifted;
		logic signed [HW:0]      sum;
		diff    = $signed({1'b0, b}) - $signed({1'b0, a});
		prod    = (HW+FB+2)'(diff) * (HW+FB+2)'($signed({1'b0, w}));
		shifted = prod >>> FB;
		sum     = $signed({1'b0, a}) + shifted[HW:0];
		return sum[HW-1:0];
	endfunction

	seq_state_t state_q;

	logic [31:0]    frac_x_wide;
	logic [31:0]    frac_y_wide;
	logic [SW-1:0]  size_eff;
	logic [FB-1:0]  fx_q;
	logic [FB-1:0]  fy_q;
	logic [SW-1:0]  size_q;
	logic [LW-1:0]  last_q;
	logic [PW-1:0]  px_q;
	logic [PW-1:0]  py_q;
	logic [LW-1:0]  x0;
	logic [LW-1:0]  y0;
	logic [LW-1:0]  x1;
	logic [LW-1:0]  y1;
	logic [RW-1:0]  row0_full;
	logic [RW-1:0]  row1_full;
	logic [LW-1:0]  x0_q;
	logic [LW-1:0]  x1_q;
	logic [FB-1:0]  ax_q;
	logic [FB-1:0]  ay_q;
	logic [AW-1:0]  row0_q;
	logic [AW-1:0]  row1_q;
	logic [HW-1:0]  h00_q;
	logic [HW-1:0]  h01_q;
	logic [HW-1:0]  top_q;
	logic [HW-1:0]  bot_q;

	// query fractions cut or widened to the fraction width
	assign frac_x_wide = 32'(frac_x);
	assign frac_y_wide = 32'(frac_y);

	// tile size saturated to the supported range
	always_comb begin
		if (32'(tile_size) < 32'd2) begin
			size_eff = SW'(2);
		end else if (32'(tile_size) > 32'(MAX_TILE_SIZE)) begin
			size_eff = SW'(MAX_TILE_SIZE);
		end else begin
			size_eff = SW'(tile_size);
		end
	end

	// integer texel positions and the clamped upper neighbours
	assign x0 = px_q[PW-1:FB];
	assign y0 = py_q[PW-1:FB];
	assign x1 = (x0 >= last_q) ? last_q : x0 + LW'(1);
	assign y1 = (y0 >= last_q) ? last_q : y0 + LW'(1);
	assign row0_full = RW'(y0) * RW'(size_q);
	assign row1_full = RW'(y1) * RW'(size_q);

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_ROW;
				ST_ROW:  state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_RD3;
				ST_RD3:  state_q <= ST_WT;
				ST_WT:   state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers along the sequence
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			fx_q   <= frac_x_wide[FB-1:0];
			fy_q   <= frac_y_wide[FB-1:0];
			size_q <= size_eff;
			last_q <= LW'(size_eff - SW'(1));
		end
		if (state_q == ST_MUL) begin
			px_q <= PW'(fx_q) * PW'(last_q);
			py_q <= PW'(fy_q) * PW'(last_q);
		end
		if (state_q == ST_ROW) begin
			x0_q   <= x0;
			x1_q   <= x1;
			ax_q   <= px_q[FB-1:0];
			ay_q   <= py_q[FB-1:0];
			row0_q <= AW'(row0_full);
			row1_q <= AW'(row1_full);
		end
		if (state_q == ST_RD1) begin
			h00_q <= rd_data;
		end
		if (state_q == ST_RD2) begin
			top_q <= blend(h00_q, rd_data, ax_q);
		end
		if (state_q == ST_RD3) begin
			h01_q <= rd_data;
		end
		if (state_q == ST_WT) begin
			bot_q <= blend(h01_q, rd_data, ax_q);
		end
	end

	// texel address for each read step
	always_comb begin
		case (state_q)
			ST_RD1:  rd_addr = row0_q + AW'(x1_q);
			ST_RD2:  rd_addr = row1_q + AW'(x0_q);
			ST_RD3:  rd_addr = row1_q + AW'(x1_q);
			default: rd_addr = row0_q + AW'(x0_q);
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FIN);
	assign result    = blend(top_q, bot_q, ay_q);

`ifndef SYNTH
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_MUL))
		else $error("query start did not enter the multiply step");
	a_neighbour_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0) |-> (x1_q <= last_q && (x1_q == x0_q || x1_q == x0_q + LW'(1))))
		else $error("upper x neighbour outside tile or not adjacent");
	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN))
		else $error("finished query left while result register full");
`endif

endmodule

// File: src/rgb_height_tile_bilinear_sampler.sv
// write transaction: a new transaction can follow in the next cycle
// query transaction: result registered after the steps multiply, row, read 0 to 3, wait and
// finish; next transaction accepted when idle again, both later while a held response stalls;
// the four texel reads go one per cycle through the single height memory port
// reset: control and handshake state cleared, tile_size set to 256; height memory
// contents stay undefined until written, no clearing pass
module rgb_height_tile_bilinear_sampler #(
	parameter int MAX_TILE_SIZE = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               func,
	input  logic [rhtb_pkg::INDEX_W-1:0]       texel_index,
	input  logic [rhtb_pkg::BYTE_W-1:0]        red,
	input  logic [rhtb_pkg::BYTE_W-1:0]        green,
	input  logic [rhtb_pkg::BYTE_W-1:0]        blue,
	input  logic [rhtb_pkg::FRAC_IN_W-1:0]     frac_x,
	input  logic [rhtb_pkg::FRAC_IN_W-1:0]     frac_y,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [rhtb_pkg::HEIGHT_W-1:0]      height,
	input  logic                               cfg_we,
	input  logic [rhtb_pkg::SIZE_CFG_W-1:0]    cfg_wdata
);

	import rhtb_pkg::*;

	localparam int STORE_DEPTH = MAX_TILE_SIZE * MAX_TILE_SIZE;
	localparam int AW          = $clog2(STORE_DEPTH);

	logic [SIZE_CFG_W-1:0] tile_size_q;
	logic                  req_accept;
	logic                  start;
	logic [31:0]           index_wide;
	logic [3*BYTE_W-1:0]   raw;
	logic [HEIGHT_W-1:0]   wr_height;
	logic                  ram_we;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         ram_addr;
	logic [HEIGHT_W-1:0]   ram_rdata;
	seq_stat_t             stat;
	logic [HEIGHT_W-1:0]   result;
	logic                  out_free;
	logic                  rsp_valid_q;
	logic [HEIGHT_W-1:0]   height_q;

	// tile size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q <= TILE_SIZE_RESET;
		end else if (cfg_we) begin
			tile_size_q <= cfg_wdata;
		end
	end

	// request transaction decode
	assign req_stall  = stat.busy;
	assign req_accept = req_valid && !req_stall;
	assign start      = req_accept && (func == FUNC_QUERY);

	// encoded bytes less the bias, clamped at zero
	assign raw       = {red, green, blue};
	assign wr_height = raw[3*BYTE_W-1] ? raw[HEIGHT_W-1:0] : '0;

	// texel write, dropped beyond the store
	assign index_wide = 32'(texel_index);
	assign ram_we     = req_accept && (func == FUNC_WRITE) && (index_wide < 32'(STORE_DEPTH));
	assign ram_addr   = ram_we ? index_wide[AW-1:0] : rd_addr;

	rhtb_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wr_height),
		.rdata (ram_rdata)
	);

	rhtb_seq #(
		.MAX_TILE_SIZE (MAX_TILE_SIZE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.frac_x    (frac_x),
		.frac_y    (frac_y),
		.tile_size (tile_size_q),
		.out_free  (out_free),
		.rd_data   (ram_rdata),
		.rd_addr   (rd_addr),
		.stat      (stat),
		.result    (result)
	);

	// response register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && out_free) begin
			height_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign height    = height_q;

`ifndef SYNTH
	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !stat.busy)
		else $error("texel write during a query");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && out_free) |=> rsp_valid_q)
		else $error("finished query did not reach the response register");
`endif

endmodule
